@@ hw/rtl/chs_pkg.sv @@
// Shared types and constants for the chained hash key set.
// Holds command and status codes, controller states and the control/status structs.
// No dependencies.
package chs_pkg;

    // Field widths fixed by the item format.
    localparam int KEY_W     = 31;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 8;

    // Remainder unit: four key bits per step over a 32-bit padded key.
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = 8;
    localparam int MOD_CNT_W = 3;

    // Default table geometry.
    localparam int DEF_NUM_BUCKETS     = 16;
    localparam int DEF_WAYS_PER_BUCKET = 8;

    // Command codes; the unused code is handled as a search.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_LOOKUP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic mod_step;
        logic rd_en;
        logic commit;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic mod_done;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/chained_hash_key_set.sv @@
// Top level of the chained hash key set.
// Joins chs_ctrl and chs_datapath; uses chs_pkg.
//
// Usage:
// A set of 31-bit keys in NUM_BUCKETS buckets of WAYS_PER_BUCKET ways each.
// Each input word on the s_ group carries a command (insert, delete, search)
// and a key; each accepted word gives exactly one result word on the m_ group
// with a status: done or found, not found, or bucket full on insert.
// The bucket is key modulo NUM_BUCKETS.
// Sequence: with a power-of-two bucket count an item goes through accept and
// row read, then compare and write back, and its result shows on m_tvalid in
// the cycle after the write back. Other bucket counts add 8 remainder steps of
// four key bits each and one row read between accept and compare. Compare and
// write back wait while the output register is not free.
// Reset: a clearing pass writes every bucket row empty, one row per cycle;
// s_tready stays low until it ends.
// Stall: a result waits in the output register; the next item is accepted
// meanwhile, and its lookup holds until the output register is free.
module chained_hash_key_set
    import chs_pkg::*;
#(
    parameter int NUM_BUCKETS     = DEF_NUM_BUCKETS,
    parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] command, [32:2] key, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] status, rest zero
);

    ctl_t                ctl;
    sts_t                sts;
    logic [STATUS_W-1:0] status;

    chs_ctrl #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    chs_datapath #(
        .NUM_BUCKETS     (NUM_BUCKETS),
        .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_command (s_tdata[CMD_W-1:0]),
        .in_key     (s_tdata[CMD_W +: KEY_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (status)
    );

    // Result word, zero padded to a byte.
    assign m_tdata = {{(OUT_DATA_W - STATUS_W){1'b0}}, status};

endmodule

@@ hw/rtl/chs_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the bucket row store. No dependencies.
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/chs_ctrl.sv @@
// Controller state machine of the chained hash key set.
// Sequences clearing, remainder steps, row read and lookup/commit. Uses chs_pkg.
module chs_ctrl
    import chs_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam bit POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.accept = 1'b1;
                    // A power-of-two bucket count reads the row right away.
                    if (POW2)
                    begin
                        ctl.rd_en  = 1'b1;
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                // Hold the row until the output register can take the result.
                if (sts.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hw/rtl/chs_datapath.sv @@
// Datapath of the chained hash key set: item registers, bucket remainder unit,
// row store, way compare and output register. Uses chs_pkg and chs_ram.
module chs_datapath
    import chs_pkg::*;
#(
    parameter int NUM_BUCKETS     = DEF_NUM_BUCKETS,
    parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    output sts_t                sts,
    input  logic [CMD_W-1:0]    in_command,
    input  logic [KEY_W-1:0]    in_key,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] out_status
);

    localparam bit POW2   = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int W      = WAYS_PER_BUCKET;
    localparam int KEYS_W = W * KEY_W;
    localparam int ROW_W  = W * (KEY_W + 1);
    localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [BW-1:0]       clr_addr_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [BW-1:0]       bucket_cur;
    logic                mod_done;

    logic              ram_we;
    logic [BW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [BW-1:0]     ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    logic [W-1:0]      row_valid;
    logic [KEYS_W-1:0] row_keys;
    logic [W-1:0]      match_vec;
    logic [W-1:0]      free_vec;
    logic [W-1:0]      match_first;
    logic [W-1:0]      free_first;
    logic [W-1:0]      new_valid;
    logic [KEYS_W-1:0] new_keys;
    logic              is_insert;
    logic              is_delete;
    logic              has_match;
    logic              has_free;
    logic              row_write;

    // Item registers, loaded when a word is accepted.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= in_command;
            key_reg <= in_key;
        end
    end

    // Bucket index: a mask for power-of-two counts, else a stepped remainder.
    generate
        if (POW2)
        begin : g_mask
            assign bucket_cur = key_reg[BW-1:0];
            assign mod_done   = 1'b1;
        end
        else
        begin : g_rem
            localparam logic [BW:0] NB_EXT = (BW+1)'(NUM_BUCKETS);

            logic [KEY_W:0]         work_reg;
            logic [BW-1:0]          rem_reg;
            logic [MOD_CNT_W-1:0]   cnt_reg;
            logic [BW-1:0]          rem_next;

            // Four restoring remainder steps on the top key bits.
            always_comb
            begin
                logic [BW:0]   t;
                logic [BW-1:0] r;
                r = rem_reg;
                for (int i = 0; i < MOD_DIGIT; i++)
                begin
                    t = {r, work_reg[KEY_W - i]};
                    if (t >= NB_EXT)
                    begin
                        t = t - NB_EXT;
                    end
                    r = t[BW-1:0];
                end
                rem_next = r;
            end

            always_ff @(posedge clk)
            begin
                if (ctl.accept)
                begin
                    work_reg <= {1'b0, in_key};
                    rem_reg  <= '0;
                end
                else if (ctl.mod_step)
                begin
                    work_reg <= work_reg << MOD_DIGIT;
                    rem_reg  <= rem_next;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= '0;
                end
                else if (ctl.accept)
                begin
                    cnt_reg <= '0;
                end
                else if (ctl.mod_step)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            assign bucket_cur = rem_reg;
            assign mod_done   = (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
        end
    endgenerate

    // Clearing pass address after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (ctl.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Way compare on the row that was read.
    assign row_valid = ram_rdata[ROW_W-1 -: W];
    assign row_keys  = ram_rdata[KEYS_W-1:0];

    always_comb
    begin
        for (int w = 0; w < W; w++)
        begin
            match_vec[w] = row_valid[w] && (row_keys[w*KEY_W +: KEY_W] == key_reg);
        end
    end

    assign free_vec    = ~row_valid;
    // Lowest set bit picks the first way in chain order.
    assign match_first = match_vec & (~match_vec + 1'b1);
    assign free_first  = free_vec & (~free_vec + 1'b1);
    assign has_match   = |match_vec;
    assign has_free    = |free_vec;
    assign is_insert   = (cmd_reg == CMD_INSERT);
    assign is_delete   = (cmd_reg == CMD_DELETE);

    // Updated row for insert or delete.
    always_comb
    begin
        new_keys = row_keys;
        for (int w = 0; w < W; w++)
        begin
            if (free_first[w])
            begin
                new_keys[w*KEY_W +: KEY_W] = key_reg;
            end
        end
        if (is_insert)
        begin
            new_valid = row_valid | free_first;
        end
        else
        begin
            new_valid = row_valid & ~match_first;
        end
    end

    // Result status of the current item.
    always_comb
    begin
        if (is_insert)
        begin
            status_next = has_free ? STAT_OK : STAT_FULL;
        end
        else
        begin
            status_next = has_match ? STAT_OK : STAT_NOT_FOUND;
        end
    end

    assign row_write = ctl.commit && ((is_insert && has_free) || (is_delete && has_match));

    // Row store port muxing: clearing pass or commit.
    assign ram_we    = ctl.clear || row_write;
    assign ram_waddr = ctl.clear ? clr_addr_reg : bucket_cur;
    assign ram_wdata = ctl.clear ? '0 : {new_valid, new_keys};
    assign ram_raddr = ctl.accept ? in_key[BW-1:0] : bucket_cur;

    chs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign out_status     = out_status_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.mod_done   = mod_done;
    assign sts.clear_done = (clr_addr_reg == LAST_ROW);

endmodule

@@ hw/rtl/chs_checker.sv @@
// Port-level checker for the chained hash key set, bound to the top level.
// Uses chs_pkg for widths.
module chs_checker
    import chs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Only defined status codes appear, with zero padding.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] <= STAT_FULL)
                     && (m_tdata[OUT_DATA_W-1:STATUS_W] == '0))
        else $error("undefined status code on result word");

    // The block is busy in the cycle after it accepts an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted back to back");

    // A new result appears only as the block returns ready for the next item.
    a_result_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while item still in work");

endmodule

bind chained_hash_key_set chs_checker u_chs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
